@@ src/quadratic_probe_hash_insert_unit_defines.svh @@
// assertion helpers shared by the hash insert unit
`ifndef QUADRATIC_PROBE_HASH_INSERT_UNIT_DEFINES_SVH
`define QUADRATIC_PROBE_HASH_INSERT_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define QPHI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define QPHI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/qphi_pkg.sv @@
package qphi_pkg;

  // width of the table size register
  localparam int CFG_W = 15;

  // result codes
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_PRESENT  = 2'd1,
    ST_FULL     = 2'd2,
    ST_CLEARED  = 2'd3
  } status_t;

  // commands from controller to datapath
  typedef struct packed {
    logic    load;
    logic    div_step;
    logic    probe_init;
    logic    probe_next;
    logic    mem_write_key;
    logic    sweep_step;
    logic    result_push;
    status_t result_code;
  } qphi_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic div_done;
    logic sweep_last;
    logic slot_free;
    logic key_match;
    logic wrapped;
    logic out_busy;
  } qphi_sts_t;

endpackage

@@ src/quadratic_probe_hash_insert_unit.sv @@
// Open-addressing hash table with quadratic probing. An insert beat (action 0) takes
// home = key mod size through a one-bit-a-cycle remainder unit, then probes home,
// home+1, home+4, ... one slot per cycle on the single-port slot memory. It returns
// the slot used, key already present, or no free slot once the probe comes back to home.
// A clear beat (action 1) sweeps all TABLE_DEPTH slots, one per cycle, then reports
// cleared. After reset the same clearing pass runs with in_ready low; table_size
// writes are taken at any time and should be issued only while idle. A size of zero
// acts as one, a size above TABLE_DEPTH acts as TABLE_DEPTH, and a new size does not
// clear the table.
module quadratic_probe_hash_insert_unit #(
  parameter int TABLE_DEPTH = 16384,
  parameter int KEY_WIDTH   = 31
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [qphi_pkg::CFG_W-1:0]     table_size,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           action,
  input  logic [KEY_WIDTH-1:0]           key,
  output logic                           out_valid,
  input  logic                           out_ready,
  output qphi_pkg::status_t              status,
  output logic [$clog2(TABLE_DEPTH)-1:0] slot
);

  import qphi_pkg::*;

  `include "quadratic_probe_hash_insert_unit_defines.svh"

  qphi_cmd_t cmd;
  qphi_sts_t sts;

  // the size register takes a write every cycle
  assign cfg_ready = 1'b1;

  qphi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  qphi_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_write  (cfg_valid & cfg_ready),
    .table_size (table_size),
    .key        (key),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .slot       (slot)
  );

  // checks
  `QPHI_ASSERT_IMP(a_no_accept_in_sweep, cmd.sweep_step, !in_ready, "input taken during sweep")
  `QPHI_ASSERT_IMP(a_push_not_busy, cmd.result_push, !sts.out_busy, "result over waiting beat")
  `QPHI_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second beat taken early")
  `QPHI_ASSERT_IMP(a_slot_zero, out_valid && (status != ST_INSERTED), slot == '0, "slot not zero")

endmodule

@@ src/qphi_ram.sv @@
module qphi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, read data registered and held between reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ src/qphi_ctrl.sv @@
module qphi_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                action,
  input  qphi_pkg::qphi_sts_t sts,
  output qphi_pkg::qphi_cmd_t cmd,
  output logic                in_ready
);

  import qphi_pkg::*;

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_DIV    = 7'b0000100,
    S_HOME   = 7'b0001000,
    S_CHECK  = 7'b0010000,
    S_CLEAR  = 7'b0100000,
    S_REPORT = 7'b1000000
  } ctrl_state_t;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        settled;

  // state register, clearing pass runs straight after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);
  assign settled  = sts.slot_free | sts.key_match | sts.wrapped;

  // next state and command decode
  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.result_code = ST_INSERTED;
    unique case (state)
      S_INIT: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (action) begin
            state_next = S_CLEAR;
          end else begin
            cmd.load   = 1'b1;
            state_next = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_next = S_HOME;
        end
      end
      S_HOME: begin
        cmd.probe_init = 1'b1;
        state_next     = S_CHECK;
      end
      S_CHECK: begin
        if (!settled) begin
          cmd.probe_next = 1'b1;
        end else if (!sts.out_busy) begin
          cmd.result_push = 1'b1;
          state_next      = S_IDLE;
          if (sts.slot_free) begin
            cmd.mem_write_key = 1'b1;
            cmd.result_code   = ST_INSERTED;
          end else if (sts.key_match) begin
            cmd.result_code = ST_PRESENT;
          end else begin
            cmd.result_code = ST_FULL;
          end
        end
      end
      S_CLEAR: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_REPORT;
        end
      end
      S_REPORT: begin
        if (!sts.out_busy) begin
          cmd.result_push = 1'b1;
          cmd.result_code = ST_CLEARED;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

endmodule

@@ src/qphi_dp.sv @@
module qphi_dp #(
  parameter int TABLE_DEPTH = 16384,
  parameter int KEY_WIDTH   = 31
) (
  input  logic                           clk,
  input  logic                           rst,
  input  qphi_pkg::qphi_cmd_t            cmd,
  output qphi_pkg::qphi_sts_t            sts,
  input  logic                           cfg_write,
  input  logic [qphi_pkg::CFG_W-1:0]     table_size,
  input  logic [KEY_WIDTH-1:0]           key,
  output logic                           out_valid,
  input  logic                           out_ready,
  output qphi_pkg::status_t              status,
  output logic [$clog2(TABLE_DEPTH)-1:0] slot
);

  import qphi_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int SZ_W  = $clog2(TABLE_DEPTH + 1);
  localparam int CNT_W = $clog2(KEY_WIDTH);
  localparam int MEM_W = KEY_WIDTH + 1;
  localparam logic [SZ_W-1:0] SIZE_RST =
    (TABLE_DEPTH < 11) ? SZ_W'(TABLE_DEPTH) : SZ_W'(11);

  logic [SZ_W-1:0]      size;
  logic [SZ_W-1:0]      size_cfg;
  logic [KEY_WIDTH-1:0] key_q;
  logic [KEY_WIDTH-1:0] key_sh;
  logic [SZ_W-1:0]      rem;
  logic [SZ_W:0]        trial;
  logic [CNT_W-1:0]     bit_cnt;
  logic [SZ_W-1:0]      home;
  logic [SZ_W-1:0]      pos;
  logic [SZ_W-1:0]      pos_next;
  logic [SZ_W:0]        pos_sum;
  logic [SZ_W-1:0]      step;
  logic [SZ_W-1:0]      step_next;
  logic [SZ_W:0]        step_sum;
  logic [IDX_W-1:0]     sweep_idx;
  logic [IDX_W-1:0]     mem_addr;
  logic [MEM_W-1:0]     mem_wdata;
  logic [MEM_W-1:0]     mem_rdata;
  logic                 mem_we;
  logic                 mem_re;

  // size in use: zero reads as one, saturates at the table depth
  always_comb begin
    if (table_size == '0) begin
      size_cfg = SZ_W'(1);
    end else if (32'(table_size) > 32'(TABLE_DEPTH)) begin
      size_cfg = SZ_W'(TABLE_DEPTH);
    end else begin
      size_cfg = SZ_W'(table_size);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size <= SIZE_RST;
    end else if (cfg_write) begin
      size <= size_cfg;
    end
  end

  // restoring remainder, one key bit a beat from the top
  assign trial = {rem, key_sh[KEY_WIDTH-1]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_q   <= key;
      key_sh  <= key;
      rem     <= '0;
      bit_cnt <= CNT_W'(KEY_WIDTH - 1);
    end else if (cmd.div_step) begin
      key_sh  <= key_sh << 1;
      bit_cnt <= bit_cnt - 1'b1;
      if (trial >= {1'b0, size}) begin
        rem <= SZ_W'(trial - {1'b0, size});
      end else begin
        rem <= trial[SZ_W-1:0];
      end
    end
  end

  // next probe: offsets i*i grow by 2i-1, kept reduced below size
  assign pos_sum  = {1'b0, pos} + {1'b0, step};
  assign pos_next = (pos_sum >= {1'b0, size}) ? SZ_W'(pos_sum - {1'b0, size})
                                              : pos_sum[SZ_W-1:0];
  assign step_sum = {1'b0, step} + (SZ_W + 1)'(2);

  always_comb begin
    if (size == SZ_W'(1)) begin
      step_next = '0;
    end else if (step_sum >= {1'b0, size}) begin
      step_next = SZ_W'(step_sum - {1'b0, size});
    end else begin
      step_next = step_sum[SZ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.probe_init) begin
      home <= rem;
      pos  <= rem;
      step <= (size == SZ_W'(1)) ? SZ_W'(0) : SZ_W'(1);
    end else if (cmd.probe_next) begin
      pos  <= pos_next;
      step <= step_next;
    end
  end

  // clearing sweep index wraps to zero after the last slot
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_idx <= '0;
    end else if (cmd.sweep_step) begin
      if (sweep_idx == IDX_W'(TABLE_DEPTH - 1)) begin
        sweep_idx <= '0;
      end else begin
        sweep_idx <= sweep_idx + 1'b1;
      end
    end
  end

  // slot memory port: sweep, first probe, following probe or key write
  always_comb begin
    if (cmd.sweep_step) begin
      mem_addr = sweep_idx;
    end else if (cmd.probe_init) begin
      mem_addr = rem[IDX_W-1:0];
    end else if (cmd.probe_next) begin
      mem_addr = pos_next[IDX_W-1:0];
    end else begin
      mem_addr = pos[IDX_W-1:0];
    end
  end

  assign mem_we    = cmd.sweep_step | cmd.mem_write_key;
  assign mem_re    = cmd.probe_init | cmd.probe_next;
  assign mem_wdata = cmd.sweep_step ? '0 : {1'b1, key_q};

  qphi_ram #(
    .WIDTH (MEM_W),
    .DEPTH (TABLE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_push) begin
      status <= cmd.result_code;
      slot   <= (cmd.result_code == ST_INSERTED) ? pos[IDX_W-1:0] : '0;
    end
  end

  // status back to the controller
  assign sts.div_done   = (bit_cnt == '0);
  assign sts.sweep_last = (sweep_idx == IDX_W'(TABLE_DEPTH - 1));
  assign sts.slot_free  = !mem_rdata[KEY_WIDTH];
  assign sts.key_match  = (mem_rdata[KEY_WIDTH-1:0] == key_q);
  assign sts.wrapped    = (pos_next == home);
  assign sts.out_busy   = out_valid & !out_ready;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import qphi_pkg::*;

  localparam int TABLE_DEPTH = 16384;
  localparam int KEY_W = 31;
  localparam int SLOT_W = $clog2(TABLE_DEPTH);
  localparam int DRAIN_CAP = 200000;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  typedef struct packed {
    logic act;
    logic [KEY_W-1:0] k;
  } hash_op_t;

  typedef struct packed {
    status_t status;
    logic [SLOT_W-1:0] slot;
  } hash_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] table_size = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic action = ACT_INSERT;
  logic [KEY_W-1:0] key = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  status_t status;
  logic [SLOT_W-1:0] slot;

  // stimulus and scoreboard state
  hash_op_t ops_to_send[$];
  hash_result_t results_due[$];
  logic [KEY_W-1:0] recent_keys[$];
  hash_op_t next_op;
  hash_result_t want;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;

  // shadow copy of the table and the size register
  bit slot_taken[TABLE_DEPTH];
  logic [KEY_W-1:0] slot_key[TABLE_DEPTH];
  logic [CFG_W-1:0] size_reg;

  quadratic_probe_hash_insert_unit #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_WIDTH(KEY_W)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .table_size(table_size),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .key(key),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .slot(slot)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= 200) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // apply one beat to the shadow table and return what the block should answer
  function automatic hash_result_t hash_insert_predict(logic act, logic [KEY_W-1:0] k);
    hash_result_t r;
    longint unsigned sz;
    longint unsigned home;
    longint unsigned pos;
    longint unsigned i;
    bit done;
    r.status = ST_FULL;
    r.slot = '0;
    if (act == ACT_CLEAR) begin
      foreach (slot_taken[j]) slot_taken[j] = 1'b0;
      r.status = ST_CLEARED;
    end else begin
      sz = 64'(size_reg);
      if (sz == 0) sz = 1;
      if (sz > TABLE_DEPTH) sz = TABLE_DEPTH;
      home = k % sz;
      pos = home;
      i = 0;
      done = 1'b0;
      while (!done) begin
        if (!slot_taken[pos]) begin
          slot_taken[pos] = 1'b1;
          slot_key[pos] = k;
          r.status = ST_INSERTED;
          r.slot = pos[SLOT_W-1:0];
          done = 1'b1;
        end else if (slot_key[pos] == k) begin
          r.status = ST_PRESENT;
          done = 1'b1;
        end else begin
          i++;
          pos = (home + i * i) % sz;
          // probe sequence has come back round to home
          if (pos == home || i > sz) done = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // keys biased towards colliding homes and repeats so chains grow and tables fill
  function automatic logic [KEY_W-1:0] pick_key(int unsigned eff);
    logic [KEY_W-1:0] k;
    longint unsigned span;
    span = (longint'(2147483647) - 3) / eff;
    case ($urandom_range(9))
      0, 1, 2, 3: k = KEY_W'($urandom_range(0, 4 * eff - 1));
      4, 5: begin
        if (recent_keys.size() != 0) k = recent_keys[$urandom_range(recent_keys.size() - 1)];
        else k = KEY_W'($urandom());
      end
      6, 7: k = KEY_W'(longint'(eff) * $urandom_range(0, 32'(span)) + $urandom_range(0, 3));
      default: k = KEY_W'($urandom());
    endcase
    recent_keys.push_back(k);
    if (recent_keys.size() > 16) void'(recent_keys.pop_front());
    return k;
  endfunction

  task automatic queue_op(logic act, logic [KEY_W-1:0] k);
    hash_op_t op;
    op.act = act;
    op.k = k;
    ops_to_send.push_back(op);
  endtask

  // wait until every queued beat has gone in and every result has come out,
  // looking just after the edge so the driver and monitor updates have landed
  task automatic wait_idle();
    int n = 0;
    do begin
      @(posedge clk);
      #1;
      n++;
    end while ((ops_to_send.size() != 0 || in_valid || results_due.size() != 0)
               && n < DRAIN_CAP);
  endtask

  task automatic write_table_size(logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    table_size <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    size_reg = v;
  endtask

  // input driver: launches the next pending beat, predicts on acceptance
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) results_due.push_back(hash_insert_predict(action, key));
      if (!in_valid || in_ready) begin
        if (ops_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_op = ops_to_send.pop_front();
          in_valid <= 1'b1;
          action <= next_op.act;
          key <= next_op.k;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: checks each beat against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = results_due.pop_front();
          if (status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", status, want.status));
          if (slot !== want.slot)
            report_mismatch($sformatf("slot got %0d want %0d", slot, want.slot));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // run limit
  initial begin
    #50_000_000;
    $display("** quadratic_probe_hash_insert_unit: FAILED **");
    $finish;
  end

  // sequence of phases
  initial begin
    int unsigned phase_sizes[10] = '{7, 2, 13, 1, 16384, 3, 32767, 101, 0, 5};
    int unsigned eff;
    foreach (slot_taken[j]) slot_taken[j] = 1'b0;
    size_reg = 11;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: reset size, fill until no free slot, repeats, key extremes, clear
    queue_op(ACT_INSERT, 0);
    queue_op(ACT_INSERT, 0);
    queue_op(ACT_INSERT, 11);
    queue_op(ACT_INSERT, 22);
    queue_op(ACT_INSERT, 33);
    queue_op(ACT_INSERT, 44);
    queue_op(ACT_INSERT, 55);
    queue_op(ACT_INSERT, 66);
    queue_op(ACT_INSERT, 31'h7FFF_FFFF);
    queue_op(ACT_INSERT, 31'h2AAA_AAAA);
    queue_op(ACT_INSERT, 31'h5555_5555);
    queue_op(ACT_CLEAR, 31'h7FFF_FFFF);
    queue_op(ACT_INSERT, 0);
    wait_idle();

    // size of zero behaves as one
    write_table_size('0);
    queue_op(ACT_INSERT, 5);
    queue_op(ACT_INSERT, 0);
    wait_idle();

    // size above depth saturates, old entries survive the change
    write_table_size('1);
    queue_op(ACT_INSERT, 31'h7FFF_FFFF);
    queue_op(ACT_INSERT, 16384);
    wait_idle();
    write_table_size(CFG_W'(TABLE_DEPTH));
    queue_op(ACT_INSERT, 16383 + 16384);
    wait_idle();

    // clear under a small size still empties the top of the table
    write_table_size(7);
    queue_op(ACT_CLEAR, 0);
    wait_idle();
    write_table_size(CFG_W'(TABLE_DEPTH));
    queue_op(ACT_INSERT, 31'h7FFF_FFFF);
    queue_op(ACT_INSERT, 1);
    wait_idle();

    // random phases, idling pattern rotating with the size
    for (int p = 0; p < 10; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      write_table_size(CFG_W'(phase_sizes[p]));
      eff = phase_sizes[p];
      if (eff == 0) eff = 1;
      if (eff > TABLE_DEPTH) eff = TABLE_DEPTH;
      for (int n = 0; n < 70; n++) begin
        // sender holds off until everything in flight has drained
        if (p == 3 && n == 35) wait_idle();
        if ($urandom_range(59) == 0) queue_op(ACT_CLEAR, KEY_W'($urandom()));
        else queue_op(ACT_INSERT, pick_key(eff));
      end
      wait_idle();
    end

    // tail: let any stray beat show up
    wait_idle();
    repeat (64) @(posedge clk);
    if (results_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", results_due.size()));
    if (mismatches == 0) begin
      $display("** quadratic_probe_hash_insert_unit: PASSED **");
    end else begin
      $display("** quadratic_probe_hash_insert_unit: FAILED **");
    end
    $finish;
  end

endmodule
